// File: rtl/nmea_pkg.sv
// Shared constants for the NMEA position extractor.
`default_nettype none
package nmea_pkg;

    // Sentence scan limits
    localparam int unsigned SCAN_LIMIT  = 40;
    localparam int unsigned FIELD_BYTES = 16;
    localparam int unsigned STORE_DEPTH = 16;

    // Widths
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COMMA_W = 3;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned FIELD_W = STORE_DEPTH * CHAR_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_START  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] TYPE_RST  = 8'h4C;

    // Position codes
    localparam logic [POS_W-1:0]   POS_TYPE  = 6'd4;
    localparam logic [POS_W-1:0]   POS_MAX   = 6'd63;
    localparam logic [POS_W-1:0]   POS_SCAN  = POS_W'(SCAN_LIMIT);
    localparam logic [COMMA_W-1:0] COMMA_LAT = 3'd1;
    localparam logic [COMMA_W-1:0] COMMA_LON = 3'd3;
    localparam logic [COMMA_W-1:0] COMMA_ALL = 3'd4;

endpackage : nmea_pkg
`default_nettype wire

// File: rtl/nmea_if.sv
// Channel interfaces: received byte, position result and type register write.
`default_nettype none
interface nmea_rx_if;
    import nmea_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : nmea_rx_if

interface nmea_pos_if;
    import nmea_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] lat_chars_lo;
    logic [WORD_W-1:0] lat_chars_hi;
    logic [WORD_W-1:0] lon_chars_lo;
    logic [WORD_W-1:0] lon_chars_hi;
    logic [CNT_W-1:0]  lat_length;
    logic [CNT_W-1:0]  lon_length;
    logic              truncated;
    modport source (output valid, output lat_chars_lo, output lat_chars_hi,
                    output lon_chars_lo, output lon_chars_hi, output lat_length,
                    output lon_length, output truncated, input ready);
    modport sink   (input valid, input lat_chars_lo, input lat_chars_hi,
                    input lon_chars_lo, input lon_chars_hi, input lat_length,
                    input lon_length, input truncated, output ready);
endinterface : nmea_pos_if

interface nmea_cfg_if;
    import nmea_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] type_char;
    modport source (output valid, output type_char, input ready);
    modport sink   (input valid, input type_char, output ready);
endinterface : nmea_cfg_if
`default_nettype wire

// File: rtl/nmea_field_store.sv
// Capture store for one sentence field: sequential writes, zero-padded read-out.
`default_nettype none
module nmea_field_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_wr,
    input  logic [nmea_pkg::CHAR_W-1:0]  i_ch,
    output logic [nmea_pkg::FIELD_W-1:0] o_chars,
    output logic [nmea_pkg::CNT_W-1:0]   o_count,
    output logic                         o_drop
);
    import nmea_pkg::*;

    logic [CHAR_W-1:0] r_mem [STORE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              room;

    assign room   = r_count < CNT_W'(FIELD_BYTES);
    assign o_drop = i_wr && !room;

    // Write the next character at the fill point
    always_ff @(posedge i_clk) begin
        if (i_wr && room) begin
            r_mem[r_count[IDX_W-1:0]] <= i_ch;
        end
    end

    // Advance the fill count, drop it at sentence start
    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_wr && room) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Show only filled slots; the rest read as zero
    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_slot
        assign o_chars[k*CHAR_W +: CHAR_W] = (CNT_W'(k) < r_count) ? r_mem[k] : '0;
    end

    assign o_count = r_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIELD_BYTES))
        else $error("field store fill count beyond field size");
`endif

endmodule : nmea_field_store
`default_nettype wire

// File: rtl/nmea_gll_position_extractor.sv
// Top level: NMEA sentence parser that extracts latitude and longitude fields.
//
// Usage:
//   i_rx  : one received byte per beat. Bytes outside a sentence are dropped
//           until '$' opens one; a line feed closes it.
//   o_pos : one beat per sentence whose position 4 equals the type register
//           and which holds four commas within its first 40 positions. The
//           beat carries both fields zero-padded, their lengths and a flag
//           for a field cut at 16 characters.
//   i_cfg : writes the type register (reset 'L'); always ready. Write it
//           only while no byte is in flight.
// Timing: a byte passes an input register and is parsed from there; the
//   result beat is registered once its closing line feed is parsed.
//   One byte is taken every cycle while no line feed stalls (see Stall).
// Stall: a line feed that completes a sentence waits in the input register
//   while the previous result beat is still held; all other bytes flow on.
//   No further byte is taken until the held result beat is accepted.
// Reset: clears all control state, closes any open sentence, drops any
//   pending result and sets the type register to 'L'.
`default_nettype none
module nmea_gll_position_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nmea_rx_if.sink    i_rx,
    nmea_cfg_if.sink   i_cfg,
    nmea_pos_if.source o_pos
);
    import nmea_pkg::*;

    // Input register
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_byte;

    // Parser state
    logic               r_in_sent;
    logic [POS_W-1:0]   r_pos;
    logic [COMMA_W-1:0] r_commas;
    logic               r_match;
    logic               r_ovf;
    logic [CHAR_W-1:0]  r_type_char;

    // Result register
    logic               r_out_vld;
    logic [FIELD_W-1:0] r_lat_chars;
    logic [FIELD_W-1:0] r_lon_chars;
    logic [CNT_W-1:0]   r_lat_len;
    logic [CNT_W-1:0]   r_lon_len;
    logic               r_trunc;

    logic               n_in_sent;
    logic [POS_W-1:0]   n_pos;
    logic [COMMA_W-1:0] n_commas;
    logic               n_match;
    logic               n_ovf;

    logic               match_now;
    logic               hit;
    logic               go;
    logic               scan;
    logic               start;
    logic               wr_lat;
    logic               wr_lon;
    logic               drop_lat;
    logic               drop_lon;
    logic [FIELD_W-1:0] lat_chars;
    logic [FIELD_W-1:0] lon_chars;
    logic [CNT_W-1:0]   lat_len;
    logic [CNT_W-1:0]   lon_len;

    // Decide whether the held byte closes a valid sentence
    assign match_now = r_match || (r_pos == POS_TYPE && r_in_byte == r_type_char);
    assign hit = r_in_vld && r_in_sent && r_in_byte == CH_LF && match_now
              && r_commas == COMMA_ALL;

    // Advance unless a result must wait for the held beat
    assign go = r_in_vld && (!hit || !r_out_vld || o_pos.ready);
    assign i_rx.ready  = !r_in_vld || go;
    assign i_cfg.ready = 1'b1;

    assign start = go && !r_in_sent && r_in_byte == CH_START;
    assign scan  = r_pos < POS_SCAN && r_commas < COMMA_ALL;
    assign wr_lat = go && r_in_sent && scan && r_in_byte != CH_COMMA
                 && r_in_byte != CH_LF && r_commas == COMMA_LAT;
    assign wr_lon = go && r_in_sent && scan && r_in_byte != CH_COMMA
                 && r_in_byte != CH_LF && r_commas == COMMA_LON;

    // Next parser state
    always_comb begin
        n_in_sent = r_in_sent;
        n_pos     = r_pos;
        n_commas  = r_commas;
        n_match   = r_match;
        n_ovf     = r_ovf;
        if (start) begin
            n_in_sent = 1'b1;
            n_pos     = '0;
            n_commas  = '0;
            n_match   = 1'b0;
            n_ovf     = 1'b0;
        end else if (go && r_in_sent) begin
            n_match = match_now;
            if (scan && r_in_byte == CH_COMMA) begin
                n_commas = r_commas + COMMA_W'(1);
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
            n_ovf = r_ovf || drop_lat || drop_lon;
            if (r_in_byte == CH_LF) begin
                n_in_sent = 1'b0;
            end
        end
    end

    nmea_field_store u_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (start),
        .i_wr    (wr_lat),
        .i_ch    (r_in_byte),
        .o_chars (lat_chars),
        .o_count (lat_len),
        .o_drop  (drop_lat)
    );

    nmea_field_store u_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (start),
        .i_wr    (wr_lon),
        .i_ch    (r_in_byte),
        .o_chars (lon_chars),
        .o_count (lon_len),
        .o_drop  (drop_lon)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_in_sent   <= 1'b0;
            r_pos       <= '0;
            r_commas    <= '0;
            r_match     <= 1'b0;
            r_ovf       <= 1'b0;
            r_type_char <= TYPE_RST;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_vld <= i_rx.valid;
            end
            r_in_sent <= n_in_sent;
            r_pos     <= n_pos;
            r_commas  <= n_commas;
            r_match   <= n_match;
            r_ovf     <= n_ovf;
            if (i_cfg.valid) begin
                r_type_char <= i_cfg.type_char;
            end
            if (go && hit) begin
                r_out_vld <= 1'b1;
            end else if (o_pos.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (go && hit) begin
            r_lat_chars <= lat_chars;
            r_lon_chars <= lon_chars;
            r_lat_len   <= lat_len;
            r_lon_len   <= lon_len;
            r_trunc     <= r_ovf;
        end
    end

    assign o_pos.valid        = r_out_vld;
    assign o_pos.lat_chars_lo = r_lat_chars[WORD_W-1:0];
    assign o_pos.lat_chars_hi = r_lat_chars[FIELD_W-1:WORD_W];
    assign o_pos.lon_chars_lo = r_lon_chars[WORD_W-1:0];
    assign o_pos.lon_chars_hi = r_lon_chars[FIELD_W-1:WORD_W];
    assign o_pos.lat_length   = r_lat_len;
    assign o_pos.lon_length   = r_lon_len;
    assign o_pos.truncated    = r_trunc;

`ifndef SYNTH
    a_comma_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_commas <= COMMA_ALL)
        else $error("comma count beyond four");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_pos.ready) |-> !(go && hit))
        else $error("result overwritten while held");

    a_result_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && hit) |=> (!r_in_sent && r_out_vld))
        else $error("result without sentence close");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_pos == '0 && r_commas == '0 && lat_len == '0 && lon_len == '0))
        else $error("sentence start left stale state");
`endif

endmodule : nmea_gll_position_extractor
`default_nettype wire
